/* hw/rtl/ngga_pkg.sv */
// Package for the NMEA GGA sentence parser: character codes, field widths,
// line and result types, and the constant tables for coordinate conversion.
// No dependencies.
`timescale 1ns / 1ps

package ngga_pkg;

    localparam int LINE_BUFFER_BYTES_DEF      = 120;
    localparam int MINUTE_FRACTION_DIGITS_DEF = 5;

    localparam int INT_W   = 17;
    localparam int FRAC_W  = 24;
    localparam int DEG_W   = 10;
    localparam int COORD_W = 35;

    localparam logic [31:0] STALE_LIMIT_RESET = 32'd5000;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [INT_W-1:0] INT_PART_MAX = 17'd99999;
    localparam logic [17:0] DEG_RECIP = 18'd167773;
    localparam logic [28:0] RECIP15   = 29'd286331154;

    localparam logic [3:0] FLD_LAT     = 4'd1;
    localparam logic [3:0] FLD_LAT_HEM = 4'd2;
    localparam logic [3:0] FLD_LON     = 4'd3;
    localparam logic [3:0] FLD_LON_HEM = 4'd4;
    localparam logic [3:0] FLD_FIX     = 4'd5;
    localparam logic [3:0] FLD_SATS    = 4'd6;
    localparam logic [3:0] FLD_MAX     = 4'd15;

    typedef struct packed {
        logic                         header_bad;
        logic                         star_seen;
        logic                         hex_bad;
        logic                         fields_done;
        logic [3:0]                   field_num;
        logic [7:0]                   run_xor;
        logic [7:0]                   hex_val;
        logic [1:0]                   hex_cnt;
        logic                         fld_started;
        logic                         fld_dot;
        logic                         fld_stop;
        logic [1:0][7:0]              acc;
        logic [1:0][INT_W-1:0]        ip;
        logic [1:0][FRAC_W-1:0]       frac;
        logic [1:0][2:0]              fdig;
        logic [1:0]                   nonempty;
        logic [1:0]                   negative;
    } ngga_line_t;

    typedef struct packed {
        logic [INT_W-1:0]  ip;
        logic [FRAC_W-1:0] frac;
        logic              negative;
    } ngga_coord_t;

    typedef struct packed {
        logic        ok;
        logic [7:0]  fix_q;
        logic [7:0]  sats;
        logic [31:0] now_ms;
        logic [31:0] lines;
        logic        lat_ne;
        logic        lon_ne;
    } ngga_ctrl_t;

    function automatic logic [FRAC_W-1:0] pow10(input logic [2:0] n);
        logic [FRAC_W-1:0] r;
        case (n)
            3'd0:    r = 24'd1;
            3'd1:    r = 24'd10;
            3'd2:    r = 24'd100;
            3'd3:    r = 24'd1000;
            3'd4:    r = 24'd10000;
            3'd5:    r = 24'd100000;
            3'd6:    r = 24'd1000000;
            default: r = 24'd10000000;
        endcase
        return r;
    endfunction

    // Returns a valid flag above the four-bit digit value.
    function automatic logic [4:0] hex_of(input logic [7:0] b);
        logic [4:0] r;
        if (b >= 8'h30 && b <= 8'h39)
            r = {1'b1, 4'(b - 8'h30)};
        else if (b >= 8'h41 && b <= 8'h46)
            r = {1'b1, 4'(b - 8'h37)};
        else if (b >= 8'h61 && b <= 8'h66)
            r = {1'b1, 4'(b - 8'h57)};
        else
            r = 5'd0;
        return r;
    endfunction

endpackage

/* hw/rtl/ngga_in_if.sv */
// Input channel of the GGA parser: one received byte with its timestamp.
// Depends on nothing.
`timescale 1ns / 1ps

interface ngga_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  rx_byte;
    logic [31:0] now_ms;

    modport source (output valid, rx_byte, now_ms, input ready);
    modport sink (input valid, rx_byte, now_ms, output ready);
endinterface

/* hw/rtl/ngga_out_if.sv */
// Result channel of the GGA parser: one word per terminated nonempty line.
// Depends on nothing.
`timescale 1ns / 1ps

interface ngga_out_if;
    logic               valid;
    logic               ready;
    logic               line_accepted;
    logic               position_updated;
    logic [7:0]         fix_quality;
    logic [7:0]         satellite_count;
    logic signed [34:0] latitude_e7;
    logic               latitude_valid;
    logic signed [34:0] longitude_e7;
    logic               longitude_valid;
    logic [31:0]        last_fix_ms;
    logic               fix_fresh;
    logic [31:0]        lines_seen;

    modport source (output valid, line_accepted, position_updated, fix_quality,
                    satellite_count, latitude_e7, latitude_valid, longitude_e7,
                    longitude_valid, last_fix_ms, fix_fresh, lines_seen,
                    input ready);
    modport sink (input valid, line_accepted, position_updated, fix_quality,
                  satellite_count, latitude_e7, latitude_valid, longitude_e7,
                  longitude_valid, last_fix_ms, fix_fresh, lines_seen,
                  output ready);
endinterface

/* hw/rtl/ngga_coord_conv.sv */
// Four-stage conversion of a ddmm.mmmm coordinate into signed degrees times 1e7.
// Depends on ngga_pkg.
`timescale 1ns / 1ps

module ngga_coord_conv #(
    parameter int FRAC_DIGITS = ngga_pkg::MINUTE_FRACTION_DIGITS_DEF
) (
    input  logic                             clk,
    input  logic                             adv,
    input  ngga_pkg::ngga_coord_t            coord,
    output logic signed [ngga_pkg::COORD_W-1:0] e7
);
    import ngga_pkg::*;

    localparam logic [FRAC_W-1:0] FRAC_SCALE = pow10(3'(7 - FRAC_DIGITS));

    logic [DEG_W-1:0]  deg2_reg;
    logic [INT_W-1:0]  ip2_reg;
    logic [FRAC_W-1:0] frac2_reg, frac3_reg;
    logic              neg2_reg, neg3_reg, neg4_reg, neg5_reg;
    logic [6:0]        mm3_reg;
    logic [33:0]       degp3_reg, degp4_reg, degp5_reg;
    logic [27:0]       y4_reg;
    logic [24:0]       q5_reg;

    logic [34:0] deg_prod;
    logic [29:0] x_sum;
    logic [56:0] q_prod;
    logic [34:0] mag;

    assign deg_prod = 35'(coord.ip) * 35'(DEG_RECIP);
    assign x_sum    = 30'(mm3_reg) * 30'd10000000 + 30'(frac3_reg) * 30'(FRAC_SCALE) + 30'd30;
    assign q_prod   = 57'(y4_reg) * 57'(RECIP15);
    assign mag      = 35'(degp5_reg) + 35'(q5_reg);
    assign e7       = neg5_reg ? -signed'(mag) : signed'(mag);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            deg2_reg  <= deg_prod[24 +: DEG_W];
            ip2_reg   <= coord.ip;
            frac2_reg <= coord.frac;
            neg2_reg  <= coord.negative;

            mm3_reg   <= 7'(ip2_reg - 17'(deg2_reg) * 17'd100);
            degp3_reg <= 34'(deg2_reg) * 34'd10000000;
            frac3_reg <= frac2_reg;
            neg3_reg  <= neg2_reg;

            y4_reg    <= x_sum[29:2];
            degp4_reg <= degp3_reg;
            neg4_reg  <= neg3_reg;

            q5_reg    <= q_prod[32 +: 25];
            degp5_reg <= degp4_reg;
            neg5_reg  <= neg4_reg;
        end
    end

endmodule

/* hw/rtl/nmea_gga_sentence_parser.sv */
// Streaming NMEA GGA parser: one byte per cycle, no line buffer.
// A result word becomes valid after the accepted LF byte has passed through a
// five-stage conversion pipeline followed by the output register.
// Throughput: one byte per cycle; the input stalls only while the first
// pipeline stage holds a line end that cannot move on.
// Reset clears the parse state, the stored fix and the line counter.
`timescale 1ns / 1ps

module nmea_gga_sentence_parser #(
    parameter int LINE_BUFFER_BYTES      = ngga_pkg::LINE_BUFFER_BYTES_DEF,
    parameter int MINUTE_FRACTION_DIGITS = ngga_pkg::MINUTE_FRACTION_DIGITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ngga_in_if.sink     in_ch,
    ngga_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);
    import ngga_pkg::*;

    localparam int LW    = $clog2(LINE_BUFFER_BYTES);
    localparam int DEPTH = 5;

    logic [31:0]        limit_reg;
    logic [LW-1:0]      len_reg, len_next;
    ngga_line_t         line_reg, line_next;
    logic [31:0]        cnt_reg, cnt_next;

    logic [DEPTH-1:0]   vld_reg;
    ngga_ctrl_t         ctrl_reg [DEPTH];
    ngga_ctrl_t         snap;
    ngga_coord_t        coord_reg [2];
    logic               emit;
    logic               accept;
    logic               adv;

    logic signed [COORD_W-1:0] e7 [2];

    logic [7:0]         st_fixq_reg, st_sats_reg;
    logic [COORD_W-1:0] st_lat_reg, st_lon_reg;
    logic               st_latv_reg, st_lonv_reg;
    logic [31:0]        st_time_reg;
    logic               out_valid_reg, acc_out_reg, upd_out_reg, fresh_out_reg;
    logic [31:0]        lines_out_reg;

    logic [7:0]         new_fixq;
    logic               new_upd;
    logic [31:0]        new_time;

    assign adv          = !out_valid_reg || out_ch.ready;
    assign in_ch.ready  = adv || !vld_reg[0];
    assign accept       = in_ch.valid && in_ch.ready;

    always_comb
    begin
        logic [7:0]       b;
        logic [3:0]       d;
        logic             digit;
        logic [LW-1:0]    pos;
        logic [4:0]       hx;
        logic             first;
        logic             ci;
        logic [19:0]      v;

        b         = in_ch.rx_byte;
        digit     = (b >= 8'h30) && (b <= 8'h39);
        d         = digit ? 4'(b - 8'h30) : 4'd0;
        pos       = len_reg;
        hx        = hex_of(b);
        first     = !line_reg.fld_started;
        ci        = 1'b0;
        v         = '0;
        line_next = line_reg;
        len_next  = len_reg;
        cnt_next  = cnt_reg;
        emit      = 1'b0;

        snap.ok     = !line_reg.header_bad && (len_reg >= LW'(7)) && line_reg.star_seen &&
                      (line_reg.hex_cnt == 2'd2) && !line_reg.hex_bad &&
                      (line_reg.hex_val == line_reg.run_xor) && (line_reg.field_num >= FLD_SATS);
        snap.fix_q  = line_reg.acc[0];
        snap.sats   = line_reg.acc[1];
        snap.now_ms = in_ch.now_ms;
        snap.lines  = cnt_reg + 32'd1;
        snap.lat_ne = line_reg.nonempty[0];
        snap.lon_ne = line_reg.nonempty[1];

        if (accept)
        begin
            if (b == CH_LF)
            begin
                if (len_reg != '0)
                begin
                    emit      = 1'b1;
                    cnt_next  = cnt_reg + 32'd1;
                    line_next = '0;
                    len_next  = '0;
                end
            end
            else if (len_reg >= LW'(LINE_BUFFER_BYTES - 1))
            begin
                line_next = '0;
                len_next  = '0;
            end
            else
            begin
                len_next = len_reg + LW'(1);
                if ((pos == LW'(0) && b != CH_DOLLAR) ||
                    ((pos == LW'(3) || pos == LW'(4)) && b != CH_G) ||
                    (pos == LW'(5) && b != CH_A) || (pos == LW'(6) && b != CH_COMMA))
                    line_next.header_bad = 1'b1;

                if (pos != LW'(0))
                begin
                    if (line_reg.star_seen)
                    begin
                        if (line_reg.hex_cnt != 2'd2)
                        begin
                            if (!hx[4])
                                line_next.hex_bad = 1'b1;
                            else
                                line_next.hex_val = {line_reg.hex_val[3:0], hx[3:0]};
                            line_next.hex_cnt = line_reg.hex_cnt + 2'd1;
                        end
                    end
                    else if (b == CH_STAR)
                        line_next.star_seen = 1'b1;
                    else
                        line_next.run_xor = line_reg.run_xor ^ b;
                end

                if (pos >= LW'(7) && !line_reg.fields_done)
                begin
                    if (b == CH_COMMA)
                    begin
                        if (line_reg.field_num != FLD_MAX)
                            line_next.field_num = line_reg.field_num + 4'd1;
                        line_next.fld_started = 1'b0;
                        line_next.fld_dot     = 1'b0;
                        line_next.fld_stop    = 1'b0;
                    end
                    else if (b == CH_STAR || b == CH_NUL)
                        line_next.fields_done = 1'b1;
                    else
                    begin
                        line_next.fld_started = 1'b1;
                        if (line_reg.field_num == FLD_LAT || line_reg.field_num == FLD_LON)
                        begin
                            ci = (line_reg.field_num == FLD_LON);
                            line_next.nonempty[ci] = 1'b1;
                            if (!line_reg.fld_stop)
                            begin
                                if (digit)
                                begin
                                    if (!line_reg.fld_dot)
                                    begin
                                        v = 20'(line_reg.ip[ci]) * 20'd10 + 20'(d);
                                        line_next.ip[ci] = (v > 20'(INT_PART_MAX)) ?
                                                           INT_PART_MAX : INT_W'(v);
                                    end
                                    else if (line_reg.fdig[ci] < 3'(MINUTE_FRACTION_DIGITS))
                                    begin
                                        line_next.frac[ci] = line_reg.frac[ci] +
                                            FRAC_W'(d) * pow10(3'(MINUTE_FRACTION_DIGITS - 1)
                                                               - line_reg.fdig[ci]);
                                        line_next.fdig[ci] = line_reg.fdig[ci] + 3'd1;
                                    end
                                end
                                else if (b == CH_DOT && !line_reg.fld_dot)
                                    line_next.fld_dot = 1'b1;
                                else
                                    line_next.fld_stop = 1'b1;
                            end
                        end
                        else if (line_reg.field_num == FLD_LAT_HEM ||
                                 line_reg.field_num == FLD_LON_HEM)
                        begin
                            ci = (line_reg.field_num == FLD_LON_HEM);
                            if (first)
                                line_next.negative[ci] = (b == CH_S) || (b == CH_W);
                        end
                        else if (line_reg.field_num == FLD_FIX ||
                                 line_reg.field_num == FLD_SATS)
                        begin
                            ci = (line_reg.field_num == FLD_SATS);
                            if (!line_reg.fld_stop)
                            begin
                                if (digit)
                                    line_next.acc[ci] = 8'(line_reg.acc[ci] * 8'd10 + 8'(d));
                                else
                                    line_next.fld_stop = 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= STALE_LIMIT_RESET;
            len_reg   <= '0;
            line_reg  <= '0;
            cnt_reg   <= '0;
            vld_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                limit_reg <= cfg_wdata;
            len_reg  <= len_next;
            line_reg <= line_next;
            cnt_reg  <= cnt_next;
            if (adv)
                vld_reg <= {vld_reg[DEPTH-2:0], emit};
            else
                vld_reg[0] <= vld_reg[0] | emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ctrl_reg[0]  <= snap;
            coord_reg[0] <= '{ip: line_reg.ip[0], frac: line_reg.frac[0],
                              negative: line_reg.negative[0]};
            coord_reg[1] <= '{ip: line_reg.ip[1], frac: line_reg.frac[1],
                              negative: line_reg.negative[1]};
        end
        if (adv)
        begin
            for (int k = 1; k < DEPTH; k++)
                ctrl_reg[k] <= ctrl_reg[k-1];
        end
    end

    for (genvar c = 0; c < 2; c++)
    begin : g_conv
        ngga_coord_conv #(
            .FRAC_DIGITS(MINUTE_FRACTION_DIGITS)
        ) u_conv (
            .clk   (clk),
            .adv   (adv),
            .coord (coord_reg[c]),
            .e7    (e7[c])
        );
    end

    assign new_fixq = ctrl_reg[DEPTH-1].ok ? ctrl_reg[DEPTH-1].fix_q : st_fixq_reg;
    assign new_upd  = ctrl_reg[DEPTH-1].ok && (ctrl_reg[DEPTH-1].fix_q != 8'd0);
    assign new_time = new_upd ? ctrl_reg[DEPTH-1].now_ms : st_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            st_fixq_reg   <= '0;
            st_sats_reg   <= '0;
            st_lat_reg    <= '0;
            st_lon_reg    <= '0;
            st_latv_reg   <= 1'b0;
            st_lonv_reg   <= 1'b0;
            st_time_reg   <= '0;
        end
        else if (adv && vld_reg[DEPTH-1])
        begin
            out_valid_reg <= 1'b1;
            st_fixq_reg   <= new_fixq;
            if (ctrl_reg[DEPTH-1].ok)
                st_sats_reg <= ctrl_reg[DEPTH-1].sats;
            if (new_upd)
            begin
                st_latv_reg <= ctrl_reg[DEPTH-1].lat_ne;
                st_lonv_reg <= ctrl_reg[DEPTH-1].lon_ne;
                st_lat_reg  <= ctrl_reg[DEPTH-1].lat_ne ? COORD_W'(e7[0]) : '0;
                st_lon_reg  <= ctrl_reg[DEPTH-1].lon_ne ? COORD_W'(e7[1]) : '0;
            end
            st_time_reg <= new_time;
        end
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv && vld_reg[DEPTH-1])
        begin
            acc_out_reg   <= ctrl_reg[DEPTH-1].ok;
            upd_out_reg   <= new_upd;
            fresh_out_reg <= (new_fixq != 8'd0) &&
                             ((ctrl_reg[DEPTH-1].now_ms - new_time) < limit_reg);
            lines_out_reg <= ctrl_reg[DEPTH-1].lines;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.line_accepted    = acc_out_reg;
    assign out_ch.position_updated = upd_out_reg;
    assign out_ch.fix_quality      = st_fixq_reg;
    assign out_ch.satellite_count  = st_sats_reg;
    assign out_ch.latitude_e7      = signed'(st_lat_reg);
    assign out_ch.latitude_valid   = st_latv_reg;
    assign out_ch.longitude_e7     = signed'(st_lon_reg);
    assign out_ch.longitude_valid  = st_lonv_reg;
    assign out_ch.last_fix_ms      = st_time_reg;
    assign out_ch.fix_fresh        = fresh_out_reg;
    assign out_ch.lines_seen       = lines_out_reg;

endmodule
